// ===== rtl/core/bss_pkg.sv =====
// shared constants, types and codes for the bounded set store
`default_nettype none

package bss_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 16;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int FUNC_W      = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_QUERY  = 2'd2,
        FUNC_SPARE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_RESOLVE,
        ST_UPDATE
    } state_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic live;
        logic ins_en;
        logic shift_en;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/bounded_set_store_core.sv =====
// top level of the bounded set store: sequencer, count and the row of cells
//
// Keeps a packed set of up to CAPACITY distinct values and a count.
// Input channel (in_valid/in_ready) carries func and element: insert,
// delete or membership query. Output channel (out_valid/out_ready)
// returns one result per request: was_member, entry_count, empty_flag,
// full_flag and refused.
// Each request runs through compare, encode and update cycles: the
// result is written to the output register at the end of the update
// cycle. One request is worked on at a time; in_ready rises again
// once the result sits in the output register. The cells compare all
// entries at once; a delete shifts the entries above the hit down by
// one in the update cycle. If the receiver stalls, the next request
// still enters and waits in its update cycle until the output
// register is free.
// Reset clears the count and the handshake state; stored values are not
// cleared, entries at or beyond the count are never used.
`default_nettype none

module bounded_set_store_core
    import bss_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [FUNC_W-1:0]      func,
    input  wire logic [VALUE_WIDTH-1:0] element,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        was_member,
    output logic      [CNT_W-1:0]       entry_count,
    output logic                        empty_flag,
    output logic                        full_flag,
    output logic                        refused
);

    state_t                 state_reg;
    state_t                 state_next;
    func_t                  func_reg;
    logic [VALUE_WIDTH-1:0] element_reg;
    logic                   hit_reg;
    logic [IDX_W-1:0]       pos_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    logic                   out_valid_reg;
    logic                   was_member_reg;
    logic [CNT_W-1:0]       entry_count_reg;
    logic                   empty_flag_reg;
    logic                   full_flag_reg;
    logic                   refused_reg;

    logic                   load_req;
    logic                   load_resolve;
    logic                   commit;
    logic                   hit;
    logic [IDX_W-1:0]       pos;
    logic                   is_full;
    logic                   is_ins;
    logic                   is_del;
    logic                   do_ins;
    logic                   do_del;
    logic                   refuse;

    logic [CAPACITY-1:0]    match_vec;
    logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
    cell_ctrl_t             cell_ctrl  [CAPACITY];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:  state_next = ST_RESOLVE;
            ST_RESOLVE: state_next = ST_UPDATE;
            ST_UPDATE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready     = 1'b0;
        load_resolve = 1'b0;
        commit       = 1'b0;
        unique case (state_reg)
            ST_IDLE:    in_ready = 1'b1;
            ST_LOOKUP:  ;
            ST_RESOLVE: load_resolve = 1'b1;
            ST_UPDATE:  commit = !out_valid_reg || out_ready;
            default:    ;
        endcase
    end

    assign load_req = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_req)
        begin
            func_reg    <= func_t'(func);
            element_reg <= element;
        end
        if (load_resolve)
        begin
            hit_reg <= hit;
            pos_reg <= pos;
        end
        if (commit)
        begin
            was_member_reg  <= hit_reg;
            entry_count_reg <= count_next;
            empty_flag_reg  <= (count_next == '0);
            full_flag_reg   <= (count_next == CNT_W'(CAPACITY));
            refused_reg     <= refuse;
        end
    end

    // update decisions
    always_comb
    begin
        is_full    = (count_reg == CNT_W'(CAPACITY));
        is_ins     = (func_reg == FUNC_INSERT);
        is_del     = (func_reg == FUNC_DELETE);
        refuse     = is_ins && !hit_reg && is_full;
        do_ins     = commit && is_ins && !hit_reg && !is_full;
        do_del     = commit && is_del && hit_reg;
        count_next = count_reg;
        if (do_ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_del)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [VALUE_WIDTH-1:0] right_value;

            if (g == CAPACITY - 1)
            begin : g_last
                assign right_value = cell_value[g];
            end
            else
            begin : g_inner
                assign right_value = cell_value[g+1];
            end

            always_comb
            begin
                cell_ctrl[g].live     = (count_reg > CNT_W'(g));
                cell_ctrl[g].ins_en   = do_ins && (count_reg[IDX_W-1:0] == IDX_W'(g));
                cell_ctrl[g].shift_en = do_del && (pos_reg <= IDX_W'(g));
            end

            bss_cell u_cell (
                .clk            (clk),
                .ctrl           (cell_ctrl[g]),
                .element        (element_reg),
                .neighbor_value (right_value),
                .value          (cell_value[g]),
                .match          (match_vec[g])
            );
        end
    endgenerate

    bss_encode u_encode (
        .match (match_vec),
        .hit   (hit),
        .pos   (pos)
    );

    assign out_valid   = out_valid_reg;
    assign was_member  = was_member_reg;
    assign entry_count = entry_count_reg;
    assign empty_flag  = empty_flag_reg;
    assign full_flag   = full_flag_reg;
    assign refused     = refused_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bss_cell.sv =====
// one storage cell: holds a value, compares it, takes its right neighbor's value on shift
`default_nettype none

module bss_cell
    import bss_pkg::*;
(
    input  wire logic                   clk,
    input  wire cell_ctrl_t             ctrl,
    input  wire logic [VALUE_WIDTH-1:0] element,
    input  wire logic [VALUE_WIDTH-1:0] neighbor_value,
    output logic      [VALUE_WIDTH-1:0] value,
    output logic                        match
);

    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;
    logic                   match_reg;
    logic                   match_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.ins_en)
        begin
            value_next = element;
        end
        else if (ctrl.shift_en)
        begin
            value_next = neighbor_value;
        end
        match_next = ctrl.live && (value_reg == element);
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        match_reg <= match_next;
    end

    assign value = value_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bss_encode.sv =====
// turns the row of match bits into a hit flag and the matching position
`default_nettype none

module bss_encode
    import bss_pkg::*;
(
    input  wire logic [CAPACITY-1:0] match,
    output logic                     hit,
    output logic      [IDX_W-1:0]    pos
);

    // values are distinct, so at most one bit is set
    always_comb
    begin
        hit = |match;
        pos = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            pos = pos | (match[i] ? IDX_W'(i) : IDX_W'(0));
        end
    end

endmodule

`default_nettype wire

// ===== test/bounded_set_store_core_test.sv =====
// testbench for the bounded set store: random insert, delete and query traffic against a set model
`timescale 1ns / 1ps

module bounded_set_store_core_test
    import bss_pkg::*;
();

    localparam int POOL_SIZE   = 96;
    localparam int PHASE_ITEMS = 450;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 20;

    typedef struct packed {
        logic             was_member;
        logic [CNT_W-1:0] entry_count;
        logic             empty_flag;
        logic             full_flag;
        logic             refused;
    } set_reply_t;

    class set_scoreboard;
        logic [VALUE_WIDTH-1:0] mirror [CAPACITY];
        int                     held;
        set_reply_t             pending [$];
        int                     errors;

        function new();
            held   = 0;
            errors = 0;
        endfunction

        // apply one accepted request to the mirror and queue the reply it must produce
        function void note_request(func_t op, logic [VALUE_WIDTH-1:0] value);
            set_reply_t reply;
            int         pos;
            pos = -1;
            for (int i = 0; i < held; i++)
            begin
                if (pos < 0 && mirror[i] == value)
                    pos = i;
            end
            reply.was_member = (pos >= 0);
            reply.refused    = 1'b0;
            case (op)
                FUNC_INSERT:
                begin
                    if (pos < 0)
                    begin
                        if (held == CAPACITY)
                            reply.refused = 1'b1;
                        else
                        begin
                            mirror[held] = value;
                            held++;
                        end
                    end
                end
                FUNC_DELETE:
                begin
                    if (pos >= 0)
                    begin
                        // keep the store packed
                        for (int j = pos; j < held - 1; j++)
                            mirror[j] = mirror[j + 1];
                        held--;
                    end
                end
                default: ;
            endcase
            reply.entry_count = CNT_W'(held);
            reply.empty_flag  = (held == 0);
            reply.full_flag   = (held == CAPACITY);
            pending.push_back(reply);
        endfunction

        function void check_result(set_reply_t got);
            set_reply_t want;
            if (pending.size() == 0)
            begin
                $error("result with no request outstanding, entry_count %0d", got.entry_count);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.was_member !== want.was_member)
            begin
                $error("was_member: expected %0d, got %0d", want.was_member, got.was_member);
                errors++;
            end
            if (got.entry_count !== want.entry_count)
            begin
                $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
                errors++;
            end
            if (got.empty_flag !== want.empty_flag)
            begin
                $error("empty_flag: expected %0d, got %0d", want.empty_flag, got.empty_flag);
                errors++;
            end
            if (got.full_flag !== want.full_flag)
            begin
                $error("full_flag: expected %0d, got %0d", want.full_flag, got.full_flag);
                errors++;
            end
            if (got.refused !== want.refused)
            begin
                $error("refused: expected %0d, got %0d", want.refused, got.refused);
                errors++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [FUNC_W-1:0]      func;
    logic [VALUE_WIDTH-1:0] element;
    logic                   out_valid;
    logic                   out_ready;
    logic                   was_member;
    logic [CNT_W-1:0]       entry_count;
    logic                   empty_flag;
    logic                   full_flag;
    logic                   refused;

    int                     sender_idle_pct;
    int                     receiver_stall_pct;
    logic [VALUE_WIDTH-1:0] value_pool [POOL_SIZE];
    set_scoreboard          sb = new();

    bounded_set_store_core u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .element     (element),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .was_member  (was_member),
        .entry_count (entry_count),
        .empty_flag  (empty_flag),
        .full_flag   (full_flag),
        .refused     (refused)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // one request per call; valid stays up across back-to-back transfers
    task automatic send_request(func_t op, logic [VALUE_WIDTH-1:0] value);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        func     = op;
        element  = value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(op, value);
    endtask

    // bursts that lean toward filling, draining or mixed traffic over a pool of values
    task automatic run_traffic(int count);
        int                     mode;
        int                     burst_left;
        int                     pick;
        func_t                  op;
        logic [VALUE_WIDTH-1:0] value;
        mode       = 0;
        burst_left = 110;
        for (int n = 0; n < count; n++)
        begin
            if (burst_left == 0)
            begin
                mode       = $urandom_range(2);
                burst_left = $urandom_range(30, 120);
            end
            burst_left--;
            pick = $urandom_range(99);
            case (mode)
                0:       op = (pick < 75) ? FUNC_INSERT : (pick < 85) ? FUNC_DELETE : FUNC_QUERY;
                1:       op = (pick < 70) ? FUNC_DELETE : (pick < 80) ? FUNC_INSERT : FUNC_QUERY;
                default: op = (pick < 35) ? FUNC_INSERT : (pick < 70) ? FUNC_DELETE : FUNC_QUERY;
            endcase
            if (op == FUNC_QUERY && $urandom_range(3) == 0)
                op = FUNC_SPARE;
            if ($urandom_range(9) == 0)
                value = VALUE_WIDTH'($urandom);
            else
                value = value_pool[$urandom_range(POOL_SIZE - 1)];
            send_request(op, value);
        end
    endtask

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result({was_member, entry_count, empty_flag, full_flag, refused});
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("bounded_set_store_core_test failed");
        $finish;
    end

    initial
    begin
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        func               = FUNC_INSERT;
        element            = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        value_pool[0]      = '0;
        value_pool[1]      = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            value_pool[i] = VALUE_WIDTH'($urandom);
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // empty set, extremes, duplicates, absent deletes, middle/first/last deletes
        send_request(FUNC_QUERY,  16'h0000);
        send_request(FUNC_DELETE, 16'h0000);
        send_request(FUNC_INSERT, 16'h0000);
        send_request(FUNC_INSERT, 16'hFFFF);
        send_request(FUNC_INSERT, 16'h0000);
        send_request(FUNC_QUERY,  16'hFFFF);
        send_request(FUNC_SPARE,  16'hFFFF);
        send_request(FUNC_SPARE,  16'h1234);
        send_request(FUNC_INSERT, 16'h1234);
        send_request(FUNC_INSERT, 16'h8000);
        send_request(FUNC_INSERT, 16'h7FFF);
        send_request(FUNC_INSERT, 16'h0001);
        send_request(FUNC_DELETE, 16'h8000);
        send_request(FUNC_QUERY,  16'h7FFF);
        send_request(FUNC_QUERY,  16'h8000);
        send_request(FUNC_DELETE, 16'h0000);
        send_request(FUNC_DELETE, 16'h0001);
        send_request(FUNC_DELETE, 16'h5555);
        send_request(FUNC_INSERT, 16'hAAAA);
        send_request(FUNC_INSERT, 16'h5555);
        send_request(FUNC_QUERY,  16'h1234);

        run_traffic(PHASE_ITEMS);
        sender_idle_pct = 46;
        run_traffic(PHASE_ITEMS);
        sender_idle_pct    = 0;
        receiver_stall_pct = 46;
        run_traffic(PHASE_ITEMS);
        sender_idle_pct    = 9;
        receiver_stall_pct = 9;
        run_traffic(PHASE_ITEMS);

        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("bounded_set_store_core_test passed");
        else
            $display("bounded_set_store_core_test failed");
        $finish;
    end

endmodule
